### rtl/core/jfs_pkg.sv
// Shared types and constants for the JPEG frame size scanner.
// No dependencies; imported by jfs_scan_core and jpeg_frame_size_scanner.
`timescale 1ns / 1ps

package jfs_pkg;

	typedef enum logic [3:0] {
		PH_HDR    = 4'd0,
		PH_APPLEN = 4'd1,
		PH_TAG    = 4'd2,
		PH_SKIP   = 4'd3,
		PH_MARK   = 4'd4,
		PH_SLEN   = 4'd5,
		PH_PREC   = 4'd6,
		PH_DIMH   = 4'd7,
		PH_DIMW   = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		ST_FOUND     = 3'd0,
		ST_BAD_START = 3'd1,
		ST_NOT_JFIF  = 3'd2,
		ST_BAD_MARK  = 3'd3,
		ST_NO_FRAME  = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] width;
		logic [15:0] height;
	} out_word_t;

	localparam logic [31:0] SOI_APP0  = 32'hFFD8_FFE0;
	localparam logic [31:0] JFIF_TAG  = 32'h4A46_4946;
	localparam logic [15:0] MARK_MASK = 16'hFF00;
	localparam logic [15:0] SOF0_MARK = 16'hFFC0;
	localparam logic [15:0] DEF_SIZE  = 16'd100;
	localparam logic [15:0] APP0_MIN  = 16'd6;
	localparam logic [15:0] SEG_MIN   = 16'd2;

endpackage

### rtl/core/jfs_scan_core.sv
// Byte scanner: phase state, field gathering and segment skipping.
// Depends on jfs_pkg; one byte is consumed per step pulse.
`timescale 1ns / 1ps

module jfs_scan_core
	import jfs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_word_t  word,
	output logic      res_valid,
	output out_word_t res
);

	phase_t      phase_q,  phase_d;
	logic [2:0]  count_q,  count_d;
	logic [31:0] shift_q,  shift_d;
	logic [15:0] skip_q,   skip_d;
	logic [15:0] hold_q,   hold_d;
	logic        done_q,   done_d;

	logic [31:0] g;
	logic [2:0]  cnt1;
	logic [2:0]  need;
	logic        full;
	logic        hit;
	logic [2:0]  hit_st;
	logic [15:0] skip_len;
	logic        skip_go;

	assign g    = {shift_q[23:0], word.data_byte};
	assign cnt1 = count_q + 3'd1;
	assign full = (cnt1 >= need);

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		shift_d  = shift_q;
		skip_d   = skip_q;
		hold_d   = hold_q;
		done_d   = done_q;
		hit      = 1'b0;
		hit_st   = ST_BAD_MARK;
		need     = 3'd2;
		skip_len = 16'd0;
		skip_go  = 1'b0;
		res_valid = 1'b0;
		res.status = ST_BAD_MARK;
		res.width  = DEF_SIZE;
		res.height = DEF_SIZE;

		unique case (phase_q)
			PH_HDR, PH_TAG: need = 3'd4;
			PH_PREC:        need = 3'd3;
			default:        need = 3'd2;
		endcase

		if (!done_q) begin
			if (phase_q != PH_SKIP && phase_q <= PH_DIMW) begin
				shift_d = g;
				count_d = full ? 3'd0 : cnt1;
			end
			unique case (phase_q)
				PH_HDR: begin
					if (full) begin
						if (g != SOI_APP0) begin
							hit    = 1'b1;
							hit_st = ST_BAD_START;
						end else begin
							phase_d = PH_APPLEN;
						end
					end
				end
				PH_APPLEN: begin
					if (full) begin
						skip_d  = g[15:0];
						phase_d = PH_TAG;
					end
				end
				PH_TAG: begin
					if (full) begin
						if (g != JFIF_TAG) begin
							hit    = 1'b1;
							hit_st = ST_NOT_JFIF;
						end else if (skip_q < APP0_MIN) begin
							hit = 1'b1;
						end else begin
							skip_go  = 1'b1;
							skip_len = skip_q - APP0_MIN;
						end
					end
				end
				PH_SKIP: begin
					skip_d = skip_q - 16'd1;
					if (skip_q == 16'd1) phase_d = PH_MARK;
				end
				PH_MARK: begin
					if (full) begin
						if ((g[15:0] & MARK_MASK) != MARK_MASK) begin
							hit = 1'b1;
						end else begin
							phase_d = (g[15:0] == SOF0_MARK) ? PH_PREC : PH_SLEN;
						end
					end
				end
				PH_SLEN: begin
					if (full) begin
						if (g[15:0] < SEG_MIN) begin
							hit = 1'b1;
						end else begin
							skip_go  = 1'b1;
							skip_len = g[15:0] - SEG_MIN;
						end
					end
				end
				PH_PREC: begin
					if (full) phase_d = PH_DIMH;
				end
				PH_DIMH: begin
					if (full) begin
						hold_d  = g[15:0];
						phase_d = PH_DIMW;
					end
				end
				PH_DIMW: begin
					if (full) begin
						hit    = 1'b1;
						hit_st = ST_FOUND;
					end
				end
				default: hit = 1'b1;
			endcase

			// zero-length segment goes straight to the next marker word
			if (skip_go) begin
				skip_d  = skip_len;
				phase_d = (skip_len == 16'd0) ? PH_MARK : PH_SKIP;
			end

			if (hit) begin
				done_d     = 1'b1;
				res_valid  = 1'b1;
				res.status = hit_st;
				if (hit_st == ST_FOUND) begin
					res.width  = g[15:0];
					res.height = hold_q;
				end
			end else if (word.is_last) begin
				res_valid = 1'b1;
				if (phase_d == PH_HDR)
					res.status = ST_BAD_START;
				else if (phase_d == PH_APPLEN || phase_d == PH_TAG)
					res.status = ST_NOT_JFIF;
				else
					res.status = ST_NO_FRAME;
			end
		end

		// restart after the final byte of a file
		if (word.is_last) begin
			phase_d = PH_HDR;
			count_d = 3'd0;
			shift_d = 32'd0;
			skip_d  = 16'd0;
			hold_d  = 16'd0;
			done_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			count_q <= 3'd0;
			shift_q <= 32'd0;
			skip_q  <= 16'd0;
			hold_q  <= 16'd0;
			done_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			shift_q <= shift_d;
			skip_q  <= skip_d;
			hold_q  <= hold_d;
			done_q  <= done_d;
		end
	end

endmodule

### rtl/core/jpeg_frame_size_scanner.sv
// Top level of the JPEG frame size scanner: input register, scan core, result register.
// Depends on jfs_pkg and jfs_scan_core.
`timescale 1ns / 1ps

// Usage:
//   in_data carries one byte of an image file per word, with is_last set on
//   the final byte. The block checks the SOI/APP0 start, the JFIF tag, walks
//   segments by their lengths and reads height and width after SOF0.
//   out_data gives one word per file: at the first decision, or at the final
//   byte if none was reached. Failures report a size of 100 by 100.
// Timing:
//   One byte per cycle sustained while no result waits on a low out_ready.
//   A byte is held in the input register; the scan core updates its state
//   from it, and the result is written to the output register when the byte
//   advances, so out_valid rises after both registers; a pending result can stall it.
//   When the receiver stalls with a result pending, the input register still
//   takes one more byte; further bytes wait until out_ready frees the slot.
// Reset:
//   arst_n clears the scanner to the start header phase and empties both
//   registers; no clearing pass is needed. After each final byte the
//   scanner restarts on its own.
module jpeg_frame_size_scanner
	import jfs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	logic      valid_s1;
	in_word_t  word_s1;
	logic      fire;
	logic      res_valid;
	out_word_t res;
	logic      out_valid_q;
	out_word_t out_q;

	// advance the held byte only when the result slot can take it
	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_data;
		end
	end

	jfs_scan_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (fire),
		.word      (word_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### bench/jfs_result_checker.sv
// Checker for the JPEG frame size scanner: watches both channels, predicts size reports.
// Depends on jfs_pkg; instantiated by jpeg_frame_size_scanner_tb.
`timescale 1ns / 1ps

module jfs_result_checker
	import jfs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_word_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_word_t out_data,
	output int        err_count,
	output int        open_count
);

	// scanner copy
	phase_t      scan_phase;
	logic [2:0]  byte_cnt;
	logic [31:0] shift_acc;
	logic [15:0] skip_left;
	logic [15:0] height_seen;
	logic        done_flag;

	out_word_t   frame_size_q[$];
	out_word_t   want;

	task automatic clear_scan();
		scan_phase  = PH_HDR;
		byte_cnt    = '0;
		shift_acc   = '0;
		skip_left   = '0;
		height_seen = '0;
		done_flag   = 1'b0;
	endtask

	// Shift a byte in; true once the field has all its bytes.
	function automatic logic take_byte(input logic [7:0] b, input int need);
		shift_acc = {shift_acc[23:0], b};
		byte_cnt  = byte_cnt + 3'd1;
		if (byte_cnt >= need) begin
			byte_cnt = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic enter_skip(input logic [15:0] n);
		skip_left  = n;
		scan_phase = (n == 16'd0) ? PH_MARK : PH_SKIP;
	endtask

	task automatic scan_byte(input logic [7:0] b, output logic hit, output status_t code);
		logic [15:0] word;
		hit  = 1'b0;
		code = ST_FOUND;
		case (scan_phase)
		PH_HDR: begin
			if (take_byte(b, 4)) begin
				if (shift_acc != SOI_APP0) begin
					hit  = 1'b1;
					code = ST_BAD_START;
				end else begin
					scan_phase = PH_APPLEN;
				end
			end
		end
		PH_APPLEN: begin
			if (take_byte(b, 2)) begin
				skip_left  = shift_acc[15:0];
				scan_phase = PH_TAG;
			end
		end
		PH_TAG: begin
			// tag is checked ahead of the APP0 length
			if (take_byte(b, 4)) begin
				if (shift_acc != JFIF_TAG) begin
					hit  = 1'b1;
					code = ST_NOT_JFIF;
				end else if (skip_left < APP0_MIN) begin
					hit  = 1'b1;
					code = ST_BAD_MARK;
				end else begin
					enter_skip(skip_left - APP0_MIN);
				end
			end
		end
		PH_SKIP: begin
			skip_left = skip_left - 16'd1;
			if (skip_left == 16'd0)
				scan_phase = PH_MARK;
		end
		PH_MARK: begin
			if (take_byte(b, 2)) begin
				word = shift_acc[15:0];
				if ((word & MARK_MASK) != MARK_MASK) begin
					hit  = 1'b1;
					code = ST_BAD_MARK;
				end else begin
					scan_phase = (word == SOF0_MARK) ? PH_PREC : PH_SLEN;
				end
			end
		end
		PH_SLEN: begin
			if (take_byte(b, 2)) begin
				word = shift_acc[15:0];
				if (word < SEG_MIN) begin
					hit  = 1'b1;
					code = ST_BAD_MARK;
				end else begin
					enter_skip(word - SEG_MIN);
				end
			end
		end
		PH_PREC: begin
			// length word and precision byte, unchecked
			if (take_byte(b, 3))
				scan_phase = PH_DIMH;
		end
		PH_DIMH: begin
			if (take_byte(b, 2)) begin
				height_seen = shift_acc[15:0];
				scan_phase  = PH_DIMW;
			end
		end
		PH_DIMW: begin
			if (take_byte(b, 2))
				hit = 1'b1;
		end
		default: begin
			hit  = 1'b1;
			code = ST_BAD_MARK;
		end
		endcase
	endtask

	task automatic scan_file_byte(input in_word_t w);
		logic      hit;
		status_t   code;
		out_word_t rep;
		if (!done_flag) begin
			scan_byte(w.data_byte, hit, code);
			if (hit) begin
				done_flag  = 1'b1;
				rep.status = code;
				rep.width  = (code == ST_FOUND) ? shift_acc[15:0] : DEF_SIZE;
				rep.height = (code == ST_FOUND) ? height_seen : DEF_SIZE;
				frame_size_q.push_back(rep);
			end else if (w.is_last) begin
				if (scan_phase == PH_HDR)
					rep.status = ST_BAD_START;
				else if (scan_phase == PH_APPLEN || scan_phase == PH_TAG)
					rep.status = ST_NOT_JFIF;
				else
					rep.status = ST_NO_FRAME;
				rep.width  = DEF_SIZE;
				rep.height = DEF_SIZE;
				frame_size_q.push_back(rep);
			end
		end
		if (w.is_last)
			clear_scan();
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_scan();
			frame_size_q.delete();
		end else begin
			// results leave later than their byte is accepted, so compare first
			if (out_valid && out_ready) begin
				if (frame_size_q.size() == 0) begin
					if (err_count < 10)
						$display("%0t: unexpected size report: %s %0d %s %0d %s %0d",
							$realtime, "status", out_data.status,
							"width", out_data.width, "height", out_data.height);
					err_count++;
				end else begin
					want = frame_size_q.pop_front();
					if (out_data.status !== want.status || out_data.width !== want.width ||
							out_data.height !== want.height) begin
						if (err_count < 10)
							$display("%0t: size report mismatch (exp/got): %s",
								$realtime, $sformatf(
								"status %0d/%0d width %0d/%0d height %0d/%0d",
								want.status, out_data.status, want.width,
								out_data.width, want.height, out_data.height));
						err_count++;
					end
				end
			end
			if (in_valid && in_ready)
				scan_file_byte(in_data);
		end
		open_count = frame_size_q.size();
	end

endmodule

### bench/jpeg_frame_size_scanner_tb.sv
// Testbench top for the JPEG frame size scanner: clock, reset, file stimulus and verdict.
// Depends on jfs_pkg, jpeg_frame_size_scanner and jfs_result_checker.
`timescale 1ns / 1ps

module jpeg_frame_size_scanner_tb;
	import jfs_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int BYTE_GOAL   = 1600;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	in_word_t  in_data   = '0;
	logic      out_ready = 1'b0;
	logic      in_ready;
	logic      out_valid;
	out_word_t out_data;

	int        err_count;
	int        open_count;
	int        tx_idle_pct = 8;
	int        rx_idle_pct = 55;
	int        bytes_sent  = 0;
	int        quiet_cycles = 0;
	logic [7:0] file_q[$];

	always #5 clk = ~clk;

	jpeg_frame_size_scanner u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	jfs_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.err_count  (err_count),
		.open_count (open_count)
	);

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// end the run when neither channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_file();
		in_word_t w;
		foreach (file_q[i]) begin
			w.data_byte = file_q[i];
			w.is_last   = (i == file_q.size() - 1);
			send_word(w);
		end
		bytes_sent += file_q.size();
	endtask

	task automatic push_word16(input logic [15:0] v);
		file_q.push_back(v[15:8]);
		file_q.push_back(v[7:0]);
	endtask

	function automatic logic [15:0] pick_dim();
		case ($urandom_range(5))
		0:       return 16'h0000;
		1:       return 16'hFFFF;
		default: return 16'($urandom);
		endcase
	endfunction

	// Files with random content: about half well-formed, the rest broken or cut short.
	task automatic make_file();
		int         kind;
		int         flaw;
		int         app_len;
		int         seg_len;
		int         nseg;
		int         cut;
		logic [7:0] mark_lo;
		file_q.delete();
		kind = $urandom_range(99);
		if (kind < 8) begin
			repeat ($urandom_range(12, 1))
				file_q.push_back(8'($urandom));
			return;
		end
		// flaw: 1 short segment length, 2 bad marker high byte, 3 short APP0 length
		flaw = (kind < 20) ? $urandom_range(3, 1) : 0;
		push_word16(16'hFFD8);
		push_word16(16'hFFE0);
		if (flaw == 3)
			app_len = $urandom_range(5);
		else
			app_len = ($urandom_range(3) == 0) ? 6 : $urandom_range(16, 6);
		push_word16(16'(app_len));
		push_word16(JFIF_TAG[31:16]);
		push_word16(JFIF_TAG[15:0]);
		if (app_len > 6)
			repeat (app_len - 6)
				file_q.push_back(8'($urandom));
		nseg = (flaw == 1 || flaw == 2) ? $urandom_range(3, 1) : $urandom_range(3);
		for (int s = 0; s < nseg; s++) begin
			// fill bytes FF FF now and then, never SOF0 here
			mark_lo = ($urandom_range(5) == 0) ? 8'hFF : 8'($urandom);
			if (mark_lo == SOF0_MARK[7:0])
				mark_lo = 8'hC4;
			if (flaw == 2 && s == nseg - 1)
				file_q.push_back(8'($urandom_range(254)));
			else
				file_q.push_back(8'hFF);
			file_q.push_back(mark_lo);
			seg_len = (flaw == 1 && s == nseg - 1) ? $urandom_range(1) : $urandom_range(10, 2);
			push_word16(16'(seg_len));
			if (seg_len > 2)
				repeat (seg_len - 2)
					file_q.push_back(8'($urandom));
		end
		push_word16(SOF0_MARK);
		push_word16(16'($urandom));
		file_q.push_back(8'($urandom));
		push_word16(pick_dim());
		push_word16(pick_dim());
		repeat ($urandom_range(3))
			file_q.push_back(8'($urandom));
		if (flaw == 0 && kind < 35) begin
			file_q[$urandom_range(file_q.size() - 1)] = 8'($urandom);
		end else if (flaw == 0 && kind < 52) begin
			cut    = $urandom_range(file_q.size() - 1);
			file_q = file_q[0:cut];
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// end inside the start header
		file_q = '{8'h00};
		send_file();
		// bad start header decided on the final byte
		file_q = '{8'hFF, 8'hD8, 8'hFF, 8'hE1};
		send_file();
		// wrong tag, APP0 length at its minimum
		file_q = '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h06, 8'h4A, 8'h46, 8'h49, 8'h47};
		send_file();
		// APP0 length too short, then a byte that must be ignored
		file_q = '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h05, 8'h4A, 8'h46, 8'h49, 8'h46,
			8'h00};
		send_file();

		while (bytes_sent < BYTE_GOAL) begin
			if (bytes_sent >= 2 * BYTE_GOAL / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else if (bytes_sent >= BYTE_GOAL / 3) begin
				tx_idle_pct = 55;
				rx_idle_pct = 8;
			end
			make_file();
			send_file();
		end
		in_valid <= 1'b0;

		while (open_count != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (err_count == 0 && open_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
